// ===== hw/rtl/ict_pkg.sv =====
// ----------------------------------------------------------------------------
// ict_pkg
// Shared widths, codes and reset values of the idle connection aging table.
// ----------------------------------------------------------------------------
package ict_pkg;

  localparam int TABLE_ENTRIES_DEF = 32;
  localparam int TIME_BITS_DEF     = 32;

  localparam int OP_W       = 2;
  localparam int ID_W       = 16;
  localparam int KIND_W     = 3;
  localparam int IDLE_W     = 31;
  localparam int PERIOD_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
  localparam logic [OP_W-1:0] OP_REFRESH = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_IDLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 2'd2;

  localparam logic [IDLE_W-1:0]   MAX_IDLE_RST = 31'd50;
  localparam logic [PERIOD_W-1:0] PERIOD_RST   = 16'd10;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADDED  = 3'd0,
    KIND_REJECT = 3'd1,
    KIND_HIT    = 3'd2,
    KIND_MISS   = 3'd3,
    KIND_CLOSED = 3'd4
  } kind_t;

endpackage

// ===== hw/rtl/ict_ram.sv =====
// ----------------------------------------------------------------------------
// ict_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
module ict_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/idle_connection_aging_table_top.sv =====
// ----------------------------------------------------------------------------
// idle_connection_aging_table_top
// Connection id table with last-seen stamps, add/refresh lookup and periodic
// sweep that closes idle entries, walked serially by one compare unit.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       input      in_valid / in_stall    in_op, in_conn_id
//  out      output     out_valid / out_stall  out_kind, out_closed_id, out_last
//  cfg      input      cfg_wr_en              cfg_index, cfg_data
//
//  Add and refresh walk the table one entry per cycle through the RAM read port,
//  stop early on a hit and then load the result into the output register.
//  A tick without a sweep advances time, updates the sweep count and stays idle;
//  a sweep tick walks every entry, then loads the final closed result, and its
//  walk pauses while a closed result waits on a stalled output.
//  Reset clears valid bits, time and sweep count at once; no clearing pass.
//  A stalled output register pauses a sweep walk; input is taken only when idle.
// ----------------------------------------------------------------------------
module idle_connection_aging_table_top #(
  parameter int TABLE_ENTRIES = ict_pkg::TABLE_ENTRIES_DEF,
  parameter int TIME_BITS     = ict_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ict_pkg::OP_W-1:0]      in_op,
  input  logic [ict_pkg::ID_W-1:0]      in_conn_id,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ict_pkg::KIND_W-1:0]    out_kind,
  output logic [ict_pkg::ID_W-1:0]      out_closed_id,
  output logic                          out_last,
  input  logic                          cfg_wr_en,
  input  logic [ict_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ict_pkg::CFG_DATA_W-1:0] cfg_data
);

  import ict_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int CMP_W = (TIME_BITS > IDLE_W) ? TIME_BITS : IDLE_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t               state_r, state_nxt;
  logic                 sweep_r, sweep_nxt;
  logic                 add_r, add_nxt;
  logic [ID_W-1:0]      id_r, id_nxt;
  logic [CNT_W-1:0]     scan_idx_r, scan_idx_nxt;
  logic                 cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic                 free_vld_r, free_vld_nxt;
  logic [IDX_W-1:0]     free_idx_r, free_idx_nxt;
  logic                 pend_vld_r, pend_vld_nxt;
  logic [ID_W-1:0]      pend_id_r, pend_id_nxt;
  kind_t                res_kind_r, res_kind_nxt;
  logic [ID_W-1:0]      res_id_r, res_id_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [TIME_BITS-1:0] time_now_r, time_now_nxt;
  logic [PERIOD_W-1:0]  sweep_cnt_r, sweep_cnt_nxt;
  logic [IDLE_W-1:0]    max_idle_r, max_idle_nxt;
  logic [PERIOD_W-1:0]  period_r, period_nxt;
  logic                 sweep_en_r, sweep_en_nxt;
  logic                 out_valid_r, out_valid_nxt;
  kind_t                out_kind_r, out_kind_nxt;
  logic [ID_W-1:0]      out_id_r, out_id_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic [ID_W-1:0]      rd_id;
  logic [TIME_BITS-1:0] rd_stamp;
  logic                 wr_id_en;
  logic                 wr_stamp_en;
  logic [IDX_W-1:0]     wr_addr;

  logic                 out_free;
  logic                 ent_valid;
  logic                 id_match;
  logic [TIME_BITS-1:0] idle_ticks;
  logic                 expired;
  logic                 scan_end;
  logic                 hold;
  logic [PERIOD_W-1:0]  cnt_inc;

  ict_ram #(
    .WIDTH (ID_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_id_ram (
    .clk     (clk),
    .wr_en   (wr_id_en),
    .wr_addr (wr_addr),
    .wr_data (id_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_id)
  );

  ict_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (TABLE_ENTRIES)
  ) u_stamp_ram (
    .clk     (clk),
    .wr_en   (wr_stamp_en),
    .wr_addr (wr_addr),
    .wr_data (time_now_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_stamp)
  );

  assign out_free   = !out_valid_r || !out_stall;
  assign ent_valid  = valid_r[cmp_idx_r];
  assign id_match   = ent_valid && (rd_id == id_r);
  assign idle_ticks = time_now_r - rd_stamp;
  assign expired    = ent_valid && (CMP_W'(idle_ticks) > CMP_W'(max_idle_r));
  assign scan_end   = (scan_idx_r == CNT_W'(TABLE_ENTRIES));
  assign hold       = sweep_r && cmp_vld_r && expired && pend_vld_r && !out_free;
  assign cnt_inc    = sweep_cnt_r + 1'b1;
  assign rd_addr    = scan_idx_r[IDX_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    sweep_nxt     = sweep_r;
    add_nxt       = add_r;
    id_nxt        = id_r;
    scan_idx_nxt  = scan_idx_r;
    cmp_vld_nxt   = cmp_vld_r;
    cmp_idx_nxt   = cmp_idx_r;
    free_vld_nxt  = free_vld_r;
    free_idx_nxt  = free_idx_r;
    pend_vld_nxt  = pend_vld_r;
    pend_id_nxt   = pend_id_r;
    res_kind_nxt  = res_kind_r;
    res_id_nxt    = res_id_r;
    valid_nxt     = valid_r;
    time_now_nxt  = time_now_r;
    sweep_cnt_nxt = sweep_cnt_r;
    max_idle_nxt  = max_idle_r;
    period_nxt    = period_r;
    sweep_en_nxt  = sweep_en_r;
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_id_nxt    = out_id_r;
    out_last_nxt  = out_last_r;
    rd_en         = 1'b0;
    wr_id_en      = 1'b0;
    wr_stamp_en   = 1'b0;
    wr_addr       = cmp_idx_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MAX_IDLE: max_idle_nxt = cfg_data[IDLE_W-1:0];
        CFG_PERIOD:   period_nxt   = cfg_data[PERIOD_W-1:0];
        CFG_ENABLE:   sweep_en_nxt = cfg_data[0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          scan_idx_nxt = '0;
          cmp_vld_nxt  = 1'b0;
          free_vld_nxt = 1'b0;
          pend_vld_nxt = 1'b0;
          case (in_op)
            OP_ADD, OP_REFRESH: begin
              id_nxt    = in_conn_id;
              add_nxt   = (in_op == OP_ADD);
              sweep_nxt = 1'b0;
              state_nxt = ST_SCAN;
            end
            OP_TICK: begin
              time_now_nxt = time_now_r + 1'b1;
              if (!sweep_en_r) begin
                sweep_cnt_nxt = '0;
              end else if (cnt_inc >= period_r) begin
                sweep_cnt_nxt = '0;
                sweep_nxt     = 1'b1;
                state_nxt     = ST_SCAN;
              end else begin
                sweep_cnt_nxt = cnt_inc;
              end
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        if (!hold) begin
          if (!scan_end) begin
            rd_en        = 1'b1;
            scan_idx_nxt = scan_idx_r + 1'b1;
            cmp_vld_nxt  = 1'b1;
            cmp_idx_nxt  = scan_idx_r[IDX_W-1:0];
          end else begin
            cmp_vld_nxt = 1'b0;
          end
        end

        if (sweep_r) begin
          if (!hold && cmp_vld_r && expired) begin
            valid_nxt[cmp_idx_r] = 1'b0;
            if (pend_vld_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_CLOSED;
              out_id_nxt    = pend_id_r;
              out_last_nxt  = 1'b0;
            end
            pend_vld_nxt = 1'b1;
            pend_id_nxt  = rd_id;
          end
          if (scan_end && !cmp_vld_r) begin
            pend_vld_nxt = 1'b0;
            res_kind_nxt = KIND_CLOSED;
            res_id_nxt   = pend_id_r;
            state_nxt    = pend_vld_r ? ST_EMIT : ST_IDLE;
          end
        end else begin
          res_id_nxt = id_r;
          if (cmp_vld_r && id_match) begin
            wr_stamp_en  = 1'b1;
            wr_addr      = cmp_idx_r;
            res_kind_nxt = add_r ? KIND_ADDED : KIND_HIT;
            cmp_vld_nxt  = 1'b0;
            state_nxt    = ST_EMIT;
          end else begin
            if (cmp_vld_r && !ent_valid && !free_vld_r) begin
              free_vld_nxt = 1'b1;
              free_idx_nxt = cmp_idx_r;
            end
            if (scan_end && !cmp_vld_r) begin
              state_nxt = ST_EMIT;
              if (add_r && free_vld_r) begin
                wr_id_en              = 1'b1;
                wr_stamp_en           = 1'b1;
                wr_addr               = free_idx_r;
                valid_nxt[free_idx_r] = 1'b1;
                res_kind_nxt          = KIND_ADDED;
              end else if (add_r) begin
                res_kind_nxt = KIND_REJECT;
              end else begin
                res_kind_nxt = KIND_MISS;
              end
            end
          end
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = res_kind_r;
          out_id_nxt    = res_id_r;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cmp_vld_r   <= 1'b0;
      free_vld_r  <= 1'b0;
      pend_vld_r  <= 1'b0;
      valid_r     <= '0;
      time_now_r  <= '0;
      sweep_cnt_r <= '0;
      max_idle_r  <= MAX_IDLE_RST;
      period_r    <= PERIOD_RST;
      sweep_en_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      free_vld_r  <= free_vld_nxt;
      pend_vld_r  <= pend_vld_nxt;
      valid_r     <= valid_nxt;
      time_now_r  <= time_now_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      max_idle_r  <= max_idle_nxt;
      period_r    <= period_nxt;
      sweep_en_r  <= sweep_en_nxt;
      out_valid_r <= out_valid_nxt;
      sweep_r     <= sweep_nxt;
      add_r       <= add_nxt;
      id_r        <= id_nxt;
      scan_idx_r  <= scan_idx_nxt;
      cmp_idx_r   <= cmp_idx_nxt;
      free_idx_r  <= free_idx_nxt;
      pend_id_r   <= pend_id_nxt;
      res_kind_r  <= res_kind_nxt;
      res_id_r    <= res_id_nxt;
      out_kind_r  <= out_kind_nxt;
      out_id_r    <= out_id_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_closed_id = out_id_r;
  assign out_last      = out_last_r;

`ifndef SYNTHESIS
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !pend_vld_r)
    else $error("closed result left pending in idle");

  a_idle_no_compare: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !cmp_vld_r)
    else $error("compare stage busy in idle");

  a_tick_advances: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_op == OP_TICK
      |=> time_now_r == TIME_BITS'($past(time_now_r) + 1'b1))
    else $error("tick did not advance time");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r != KIND_CLOSED |-> out_last_r)
    else $error("add or refresh result without last");
`endif

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the idle connection aging table. Adds, refreshes,
// ticks and the unused opcode go in with random gaps while the result side
// stalls at random. A local copy of the table predicts every result, and each
// out transfer is checked in order under several sweep settings.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ict_pkg::*;

  localparam int ENTRIES       = TABLE_ENTRIES_DEF;
  localparam int STAMP_W       = TIME_BITS_DEF;
  localparam int SETTLE_CYCLES = 2 * ENTRIES + 8;

  localparam logic [OP_W-1:0]       OP_UNUSED = 2'd3;
  localparam logic [CFG_DATA_W-1:0] IDLE_MAX  = {IDLE_W{1'b1}};

  typedef struct packed {
    kind_t           kind;
    logic [ID_W-1:0] conn_id;
    logic            last;
  } conn_result_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_valid   = 1'b0;
  logic                  in_stall;
  logic [OP_W-1:0]       in_op      = OP_TICK;
  logic [ID_W-1:0]       in_conn_id = '0;
  logic                  out_valid;
  logic                  out_stall  = 1'b0;
  logic [KIND_W-1:0]     out_kind;
  logic [ID_W-1:0]       out_closed_id;
  logic                  out_last;
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = CFG_MAX_IDLE;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  logic                tbl_valid [ENTRIES];
  logic [ID_W-1:0]     tbl_id    [ENTRIES];
  logic [STAMP_W-1:0]  tbl_stamp [ENTRIES];
  logic [STAMP_W-1:0]  now_ticks;
  logic [PERIOD_W-1:0] ticks_since_sweep;
  logic [IDLE_W-1:0]   idle_limit;
  logic [PERIOD_W-1:0] sweep_period;
  logic                sweep_on;
  conn_result_t        owed_results [$];

  int tx_gap_max   = 0;
  int rx_stall_max = 0;
  int rx_wait      = 0;
  int items_in     = 0;
  int results_seen = 0;
  int closes_seen  = 0;
  int rejects_seen = 0;
  int fail_count   = 0;

  idle_connection_aging_table_top u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_conn_id    (in_conn_id),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_closed_id (out_closed_id),
    .out_last      (out_last),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void owe_result(kind_t kind, logic [ID_W-1:0] id, logic last);
    conn_result_t r;
    r.kind    = kind;
    r.conn_id = id;
    r.last    = last;
    owed_results.push_back(r);
  endfunction

  function automatic void age_table_apply(logic [OP_W-1:0] op, logic [ID_W-1:0] id);
    int                 slot;
    int                 freed [$];
    logic [STAMP_W-1:0] idle;
    slot = -1;
    case (op)
      OP_ADD, OP_REFRESH: begin
        for (int i = 0; i < ENTRIES; i++)
          if (slot < 0 && tbl_valid[i] && tbl_id[i] == id) slot = i;
        if (op == OP_ADD && slot < 0)
          for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && !tbl_valid[i]) slot = i;
        if (slot < 0) begin
          owe_result((op == OP_ADD) ? KIND_REJECT : KIND_MISS, id, 1'b1);
        end else begin
          tbl_valid[slot] = 1'b1;
          tbl_id[slot]    = id;
          tbl_stamp[slot] = now_ticks;
          owe_result((op == OP_ADD) ? KIND_ADDED : KIND_HIT, id, 1'b1);
        end
      end
      OP_TICK: begin
        now_ticks = now_ticks + 1'b1;
        if (!sweep_on) begin
          ticks_since_sweep = '0;
        end else begin
          ticks_since_sweep = ticks_since_sweep + 1'b1;
          if (ticks_since_sweep >= sweep_period) begin
            ticks_since_sweep = '0;
            for (int i = 0; i < ENTRIES; i++) begin
              if (tbl_valid[i]) begin
                idle = now_ticks - tbl_stamp[i];
                if (idle > {1'b0, idle_limit}) begin
                  tbl_valid[i] = 1'b0;
                  freed.push_back(i);
                end
              end
            end
            foreach (freed[k])
              owe_result(KIND_CLOSED, tbl_id[freed[k]], k == freed.size() - 1);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // track register writes and accepted input transfers
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
      now_ticks         = '0;
      ticks_since_sweep = '0;
      idle_limit        = MAX_IDLE_RST;
      sweep_period      = PERIOD_RST;
      sweep_on          = 1'b0;
      owed_results.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_MAX_IDLE: idle_limit   = cfg_data[IDLE_W-1:0];
          CFG_PERIOD:   sweep_period = cfg_data[PERIOD_W-1:0];
          CFG_ENABLE:   sweep_on     = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        age_table_apply(in_op, in_conn_id);
        items_in++;
      end
    end
  end

  always @(posedge clk) begin
    conn_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (owed_results.size() == 0) begin
        $error("unexpected result: kind %0d closed_id %h last %b",
               out_kind, out_closed_id, out_last);
        fail_count++;
      end else begin
        want = owed_results.pop_front();
        results_seen++;
        if (want.kind == KIND_CLOSED) closes_seen++;
        if (want.kind == KIND_REJECT) rejects_seen++;
        if (out_kind !== want.kind) begin
          $error("kind mismatch: expected %0d, actual %0d", want.kind, out_kind);
          fail_count++;
        end
        if (out_closed_id !== want.conn_id) begin
          $error("closed_id mismatch: expected %h, actual %h", want.conn_id, out_closed_id);
          fail_count++;
        end
        if (out_last !== want.last) begin
          $error("last mismatch: expected %b, actual %b", want.last, out_last);
          fail_count++;
        end
      end
    end
  end

  // hold off each result for a random number of cycles
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_wait   = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) rx_wait = $urandom_range(0, rx_stall_max);
      if (rx_wait > 0) begin
        out_stall <= 1'b1;
        rx_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_event(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_conn_id <= id;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_table_output();
    in_valid <= 1'b0;
    @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_table(input logic [CFG_DATA_W-1:0] idle_data,
                               input logic [CFG_DATA_W-1:0] period_data,
                               input logic [CFG_DATA_W-1:0] enable_data);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_MAX_IDLE;
    cfg_data  <= idle_data;
    @(posedge clk);
    cfg_index <= CFG_PERIOD;
    cfg_data  <= period_data;
    @(posedge clk);
    cfg_index <= CFG_ENABLE;
    cfg_data  <= enable_data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_mix(input int count, input int add_pct, input int refresh_pct,
                         input int pool);
    int              done;
    int              roll;
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] id;
    done = 0;
    while (done < count) begin
      roll = $urandom_range(0, 99);
      if (roll < add_pct) op = OP_ADD;
      else if (roll < add_pct + refresh_pct) op = OP_REFRESH;
      else if (roll < 96) op = OP_TICK;
      else op = OP_UNUSED;
      // mostly a small recurring set of ids so entries get reused and expire
      if ($urandom_range(0, 4) == 0) id = ID_W'($urandom());
      else id = ID_W'($urandom_range(0, pool - 1) * 16'h9E37) ^ 16'hC35A;
      send_event(op, id);
      if (op != OP_UNUSED) done++;
    end
  endtask

  task automatic test_directed_basics();
    tx_gap_max   = 6;
    rx_stall_max = 6;
    send_event(OP_ADD, 16'h0000);
    send_event(OP_ADD, 16'hFFFF);
    send_event(OP_ADD, 16'h5A5A);
    send_event(OP_ADD, 16'hFFFF);
    send_event(OP_REFRESH, 16'hFFFF);
    send_event(OP_REFRESH, 16'h1234);
    send_event(OP_REFRESH, 16'h0000);
    send_event(OP_UNUSED, 16'hFFFF);
    send_event(OP_TICK, 16'hFFFF);
    send_event(OP_TICK, 16'h0000);
    drain_table_output();
    program_table(31'd0, {15'h7FFF, 16'd0}, {30'h2AAAAAAA, 1'b1});
    send_event(OP_TICK, 16'hA5A5);
    send_event(OP_ADD, 16'hA5A5);
    send_event(OP_TICK, 16'h0000);
    send_event(OP_REFRESH, 16'hA5A5);
    send_event(OP_TICK, 16'h0000);
    drain_table_output();
    // idle equal to the limit stays, one more tick closes
    program_table(31'd1, {15'h0, 16'd1}, {30'h0, 1'b1});
    send_event(OP_ADD, 16'h0F0F);
    send_event(OP_TICK, 16'h0000);
    send_event(OP_TICK, 16'h0000);
    send_event(OP_UNUSED, 16'h0000);
    drain_table_output();
  endtask

  task automatic test_fast_expiry();
    program_table(31'd3, {15'($urandom()), 16'd1}, {30'($urandom()), 1'b1});
    tx_gap_max   = 18;
    rx_stall_max = 18;
    run_mix(80, 45, 20, 40);
    drain_table_output();
  endtask

  task automatic test_back_to_back_sweeps();
    program_table(31'd12, {15'($urandom()), 16'd5}, {30'($urandom()), 1'b1});
    tx_gap_max   = 0;
    rx_stall_max = 0;
    run_mix(70, 45, 25, 40);
    drain_table_output();
  endtask

  task automatic test_table_saturation();
    program_table(IDLE_MAX, {15'($urandom()), 16'hFFFF}, {30'($urandom()), 1'b1});
    tx_gap_max   = 4;
    rx_stall_max = 18;
    run_mix(80, 70, 15, 64);
    drain_table_output();
  endtask

  task automatic test_sweep_every_tick();
    program_table(31'd0, {15'($urandom()), 16'd0}, {30'($urandom()), 1'b1});
    tx_gap_max   = 18;
    rx_stall_max = 18;
    run_mix(60, 55, 15, 40);
    drain_table_output();
  endtask

  task automatic test_sweep_disabled();
    program_table(31'd2, {15'($urandom()), 16'd2}, {30'($urandom()), 1'b0});
    tx_gap_max   = 10;
    rx_stall_max = 3;
    run_mix(50, 45, 20, 40);
    drain_table_output();
  endtask

  task automatic test_reenabled_sweep();
    program_table(31'd8, {15'($urandom()), 16'd3}, {30'($urandom()), 1'b1});
    tx_gap_max   = 18;
    rx_stall_max = 18;
    run_mix(60, 40, 25, 40);
    drain_table_output();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_basics();
    test_fast_expiry();
    test_back_to_back_sweeps();
    test_table_saturation();
    test_sweep_every_tick();
    test_sweep_disabled();
    test_reenabled_sweep();
    $display("Covered %0d input transfers and %0d checked results", items_in, results_seen);
    $display("(%0d closes, %0d full-table rejects) across nine sweep settings",
             closes_seen, rejects_seen);
    if (fail_count == 0) $display("PASS idle_connection_aging_table_top");
    else $display("FAIL idle_connection_aging_table_top");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL idle_connection_aging_table_top");
    $finish;
  end

endmodule
